FILE: hdl/qpcm_pkg.sv
// ----------------------------------------------------------------------------
// qpcm_pkg
// Shared types and constants of the quad pixel coordinate mapper.
// ----------------------------------------------------------------------------
package qpcm_pkg;

   localparam int unsigned COORD_W = 32;  // stored point and register width
   localparam int unsigned DIFF_W  = 33;  // difference of two coordinates
   localparam int unsigned HALF_W  = 17;  // low half of a split operand
   localparam int unsigned OPB_W   = 18;  // signed half operand
   localparam int unsigned PROD_W  = DIFF_W + OPB_W;
   localparam int unsigned CROSS_W = 68;  // exact edge cross product

   localparam logic [2:0] CORNER_FIRST = 3'd1;
   localparam logic [2:0] CORNER_LAST  = 3'd4;

   typedef enum logic [1:0] {
      REQ_LOAD = 2'd0,
      REQ_FWD  = 2'd1,
      REQ_REV  = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      CSR_PIXEL_COUNT = 3'd0,
      CSR_ORIGIN_X    = 3'd1,
      CSR_ORIGIN_Y    = 3'd2,
      CSR_CENTER_X    = 3'd3,
      CSR_CENTER_Y    = 3'd4,
      CSR_MM_PER_CH   = 3'd5,
      CSR_FLIP_X      = 3'd6,
      CSR_FLIP_Y      = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [5:0]         pixel_count;
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic [31:0]        mm_per_ch;
      logic               flip_x;
      logic               flip_y;
   } cfg_type;

   typedef struct packed {
      logic latch;       // take a new request word
      logic load_wr;     // write the point table
      logic set_bad;     // flag a bad forward index
      logic fwd_rd;      // read the addressed point
      logic fwd_cap;     // capture the addressed point
      logic ax_start;
      logic ax_step;
      logic ax_end;
      logic ax_y;        // axis in work: 0 x, 1 y
      logic ax_div;      // 1 forward divide, 0 reverse multiply
      logic scan_clr;
      logic pix_rd;      // read first corner of the scanned pixel
      logic cap_prev;
      logic edge_rd;     // read the far corner of the current edge
      logic cap_cur;
      logic cross_step;
      logic pix_next;
      logic edge_next;
      logic set_found;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      req_kind_type kind;
      logic         idx_bad;
      logic         ax_last;
      logic         pix_more;
      logic         cross_done;
      logic         cross_neg;
      logic         edge_last;
   } sts_type;

endpackage

FILE: hdl/qpcm_ifs.sv
// ----------------------------------------------------------------------------
// qpcm channel interfaces
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface qpcm_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic [4:0]         pixel_index;
   logic [2:0]         corner_sel;
   logic signed [31:0] coord_x;
   logic signed [31:0] coord_y;
   modport source (output valid, req_type, pixel_index, corner_sel, coord_x, coord_y,
                   input ready);
   modport sink   (input valid, req_type, pixel_index, corner_sel, coord_x, coord_y,
                   output ready);
endinterface

interface qpcm_rsp_if;
   logic               valid;
   logic               ready;
   logic               status;
   logic signed [31:0] det_x;
   logic signed [31:0] det_y;
   logic               found;
   logic [4:0]         found_pixel;
   modport source (output valid, status, det_x, det_y, found, found_pixel, input ready);
   modport sink   (input valid, status, det_x, det_y, found, found_pixel, output ready);
endinterface

interface qpcm_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  reg_index;
   logic [31:0] wr_data;
   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

FILE: hdl/quad_pixel_coordinate_mapper.sv
// ----------------------------------------------------------------------------
// quad_pixel_coordinate_mapper
// Pixel table with forward (pixel to detector) and reverse (detector to pixel)
// coordinate mapping in signed fixed point.
// ----------------------------------------------------------------------------
// The block takes one request word at a time and returns one response word for
// each. A load request writes one corner or the center of a pixel into the
// table and answers with an all-zero word. A forward request for a pixel below
// both the pixel count and MAX_PIXELS reads the point and runs two restoring
// divides, one per axis, each 33+FRAC_BITS steps in a shared iterative unit;
// for any other pixel it answers with the status bit set. A reverse request
// runs two 32-step shift-add multiplies, then scans the pixels in order; each
// edge test is a corner read, a capture, four partial products through one
// 33x18 multiplier, accumulate and test. The table entries are undefined after
// reset until loaded. The next request word is accepted while the previous
// response still waits on the response channel. Registers are to be written
// through the csr channel only while the block is idle; the block itself does
// not enforce this.
// ----------------------------------------------------------------------------
module quad_pixel_coordinate_mapper import qpcm_pkg::*; #(
   parameter int unsigned MAX_PIXELS = 32,
   parameter int unsigned FRAC_BITS  = 16
) (
   input logic       clock,
   input logic       reset,
   qpcm_req_if.sink  req_ch,
   qpcm_rsp_if.source rsp_ch,
   qpcm_csr_if.sink  csr_ch
);

   cfg_type cfg_ff;
   cmd_type cmd;
   sts_type sts;

   // register file: always ready, write on valid
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_count <= 6'(MAX_PIXELS);
         cfg_ff.origin_x    <= '0;
         cfg_ff.origin_y    <= '0;
         cfg_ff.center_x    <= '0;
         cfg_ff.center_y    <= '0;
         cfg_ff.mm_per_ch   <= 32'(1) << FRAC_BITS;   // unity scale
         cfg_ff.flip_x      <= 1'b0;
         cfg_ff.flip_y      <= 1'b0;
      end else if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.reg_index))
            CSR_PIXEL_COUNT: cfg_ff.pixel_count <= csr_ch.wr_data[5:0];
            CSR_ORIGIN_X:    cfg_ff.origin_x    <= csr_ch.wr_data;
            CSR_ORIGIN_Y:    cfg_ff.origin_y    <= csr_ch.wr_data;
            CSR_CENTER_X:    cfg_ff.center_x    <= csr_ch.wr_data;
            CSR_CENTER_Y:    cfg_ff.center_y    <= csr_ch.wr_data;
            CSR_MM_PER_CH:   cfg_ff.mm_per_ch   <= csr_ch.wr_data;
            CSR_FLIP_X:      cfg_ff.flip_x      <= csr_ch.wr_data[0];
            CSR_FLIP_Y:      cfg_ff.flip_y      <= csr_ch.wr_data[0];
            default:         cfg_ff.flip_y      <= cfg_ff.flip_y;
         endcase
      end
   end

   // sequencing: hold a request word until its response word is staged
   qpcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // tables, divide/multiply unit, edge tests and the response register
   qpcm_dpath #(
      .MAX_PIXELS (MAX_PIXELS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dpath (
      .clock           (clock),
      .cfg             (cfg_ff),
      .cmd             (cmd),
      .sts             (sts),
      .req_type        (req_ch.req_type),
      .pixel_index     (req_ch.pixel_index),
      .corner_sel      (req_ch.corner_sel),
      .coord_x         (req_ch.coord_x),
      .coord_y         (req_ch.coord_y),
      .rsp_status      (rsp_ch.status),
      .rsp_det_x       (rsp_ch.det_x),
      .rsp_det_y       (rsp_ch.det_y),
      .rsp_found       (rsp_ch.found),
      .rsp_found_pixel (rsp_ch.found_pixel)
   );

endmodule

FILE: hdl/qpcm_ram.sv
// ----------------------------------------------------------------------------
// qpcm_ram
// Generic RAM, one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module qpcm_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 32,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

FILE: hdl/qpcm_dpath.sv
// ----------------------------------------------------------------------------
// qpcm_dpath
// Datapath: point tables, shared divide/multiply axis unit, edge cross unit.
// ----------------------------------------------------------------------------
module qpcm_dpath import qpcm_pkg::*; #(
   parameter int unsigned MAX_PIXELS = 32,
   parameter int unsigned FRAC_BITS  = 16
) (
   input  logic               clock,
   input  cfg_type            cfg,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic [1:0]         req_type,
   input  logic [4:0]         pixel_index,
   input  logic [2:0]         corner_sel,
   input  logic signed [31:0] coord_x,
   input  logic signed [31:0] coord_y,
   output logic               rsp_status,
   output logic signed [31:0] rsp_det_x,
   output logic signed [31:0] rsp_det_y,
   output logic               rsp_found,
   output logic [4:0]         rsp_found_pixel
);

   localparam int unsigned PIX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_PIXELS + 1);
   localparam int unsigned CMP_W = (CNT_W > 6) ? CNT_W : 6;
   localparam int unsigned CAD_W = PIX_W + 2;
   localparam int unsigned DIV_W = DIFF_W + FRAC_BITS;
   localparam int unsigned MUL_W = DIFF_W + COORD_W;
   localparam int unsigned SHR_W = MUL_W - FRAC_BITS;
   localparam int unsigned SUM_W = ((DIV_W > SHR_W) ? DIV_W : SHR_W) + 2;
   localparam int unsigned AXC_W = $clog2(DIV_W);

   // request word
   logic [1:0]         kind_ff;
   logic [4:0]         pix_ff;
   logic [2:0]         sel_ff;
   logic signed [31:0] cx_ff, cy_ff;

   // result
   logic               res_status_ff;
   logic signed [31:0] res_det_x_ff, res_det_y_ff;
   logic               res_found_ff;
   logic [4:0]         res_fpix_ff;

   // point under work
   logic signed [31:0] pt_x_ff, pt_y_ff;
   logic signed [31:0] px_ff, py_ff;

   // axis unit
   logic               ax_neg_ff, ax_div_ff;
   logic [DIFF_W-1:0]  ax_mag_ff;
   logic [31:0]        rem_ff, rem_in;
   logic [DIV_W-1:0]   dq_ff, dq_in;
   logic [MUL_W-1:0]   acc_ff, acc_in;
   logic [31:0]        mq_ff;
   logic [31:0]        divisor_ff;
   logic [AXC_W-1:0]   ax_cnt_ff;

   // edge unit
   logic [CNT_W-1:0]   scan_i_ff;
   logic [1:0]         edge_ff;
   logic signed [31:0] prev_x_ff, prev_y_ff, cur_x_ff, cur_y_ff;
   logic signed [DIFF_W-1:0] da_ff, db_ff, dc_ff, dd_ff;
   logic [2:0]         cross_k_ff;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [CROSS_W-1:0] cross_ff, cross_in;

   // RAM ports
   logic [CAD_W-1:0]   c_waddr, c_raddr;
   logic [PIX_W-1:0]   m_addr;
   logic               c_we, m_we;
   logic [63:0]        c_rd, m_rd;
   logic signed [31:0] c_rd_x, c_rd_y, m_rd_x, m_rd_y;

   // decode
   logic [CMP_W-1:0]   pix_w, cnt_w, max_w, eff_w;
   logic               in_table, is_corner;
   logic [1:0]         sel_m1, edge_nxt;
   logic [PIX_W-1:0]   pix_a, scan_a;

   // axis setup and finish
   logic signed [31:0]       ax_p, ax_ref, ax_base, ax_res;
   logic signed [DIFF_W-1:0] ax_diff;
   logic [DIFF_W-1:0]        ax_mag;
   logic [32:0]              div_shift;
   logic                     div_ge;
   logic signed [SUM_W-1:0]  mag_s, sum_s;
   logic                     sum_fits;

   // cross operands
   logic signed [DIFF_W-1:0] op_a, op_src;
   logic signed [OPB_W-1:0]  op_b;
   logic signed [CROSS_W-1:0] term;

   always_comb begin
      pix_w     = CMP_W'(pix_ff);
      cnt_w     = CMP_W'(cfg.pixel_count);
      max_w     = CMP_W'(MAX_PIXELS);
      eff_w     = (cnt_w > max_w) ? max_w : cnt_w;
      in_table  = pix_w < max_w;
      is_corner = (sel_ff >= CORNER_FIRST) && (sel_ff <= CORNER_LAST);
      sel_m1    = 2'(sel_ff - CORNER_FIRST);
      pix_a     = pix_w[PIX_W-1:0];
      scan_a    = scan_i_ff[PIX_W-1:0];
      edge_nxt  = edge_ff + 2'd1;
   end

   assign c_waddr = {pix_a, sel_m1};
   assign c_we    = cmd.load_wr && in_table && is_corner;
   assign m_we    = cmd.load_wr && in_table && !is_corner;
   assign m_addr  = pix_a;

   always_comb begin
      priority if (cmd.fwd_rd) begin
         c_raddr = {pix_a, sel_m1};
      end else if (cmd.edge_rd) begin
         c_raddr = {scan_a, edge_nxt};
      end else begin
         c_raddr = {scan_a, 2'd0};
      end
   end

   qpcm_ram #(.WIDTH(64), .DEPTH(MAX_PIXELS * 4)) u_corner_ram (
      .clock (clock),
      .we    (c_we),
      .waddr (c_waddr),
      .wdata ({cx_ff, cy_ff}),
      .raddr (c_raddr),
      .rdata (c_rd)
   );

   qpcm_ram #(.WIDTH(64), .DEPTH(MAX_PIXELS)) u_center_ram (
      .clock (clock),
      .we    (m_we),
      .waddr (m_addr),
      .wdata ({cx_ff, cy_ff}),
      .raddr (m_addr),
      .rdata (m_rd)
   );

   assign c_rd_x = c_rd[63:32];
   assign c_rd_y = c_rd[31:0];
   assign m_rd_x = m_rd[63:32];
   assign m_rd_y = m_rd[31:0];

   // axis unit: setup operands
   always_comb begin
      if (cmd.ax_div) begin
         ax_p   = cmd.ax_y ? pt_y_ff : pt_x_ff;
         ax_ref = cmd.ax_y ? cfg.origin_y : cfg.origin_x;
      end else begin
         ax_p   = cmd.ax_y ? cy_ff : cx_ff;
         ax_ref = cmd.ax_y ? cfg.center_y : cfg.center_x;
      end
      ax_diff = DIFF_W'(ax_p) - DIFF_W'(ax_ref);
      ax_mag  = ax_diff[DIFF_W-1] ? DIFF_W'(-ax_diff) : DIFF_W'(ax_diff);
   end

   // one restoring divide bit or one shift-add multiply bit per step
   always_comb begin
      div_shift = {rem_ff, dq_ff[DIV_W-1]};
      div_ge    = div_shift >= {1'b0, divisor_ff};
      rem_in    = div_ge ? 32'(div_shift - {1'b0, divisor_ff}) : div_shift[31:0];
      dq_in     = {dq_ff[DIV_W-2:0], div_ge};
      acc_in    = (acc_ff << 1) + (mq_ff[31] ? MUL_W'(ax_mag_ff) : MUL_W'(0));
   end

   // axis finish: signed add to base and saturate
   always_comb begin
      if (ax_div_ff) begin
         ax_base = cmd.ax_y ? cfg.center_y : cfg.center_x;
         mag_s   = $signed(SUM_W'(dq_ff));
      end else begin
         ax_base = cmd.ax_y ? cfg.origin_y : cfg.origin_x;
         mag_s   = $signed(SUM_W'(acc_ff >> FRAC_BITS));
      end
      sum_s    = SUM_W'(ax_base) + (ax_neg_ff ? -mag_s : mag_s);
      sum_fits = (sum_s[SUM_W-1:31] == '0) || (sum_s[SUM_W-1:31] == '1);
      if (sum_fits) begin
         ax_res = sum_s[31:0];
      end else if (sum_s[SUM_W-1]) begin
         ax_res = 32'sh8000_0000;
      end else begin
         ax_res = 32'sh7FFF_FFFF;
      end
   end

   // edge cross product in four partial products
   always_comb begin
      op_a   = (cross_k_ff < 3'd2) ? da_ff : dc_ff;
      op_src = (cross_k_ff < 3'd2) ? db_ff : dd_ff;
      if (cross_k_ff[0]) begin
         op_b = $signed({{2{op_src[DIFF_W-1]}}, op_src[DIFF_W-1:HALF_W]});
      end else begin
         op_b = $signed({1'b0, op_src[HALF_W-1:0]});
      end
      prod_in = op_a * op_b;
      term    = CROSS_W'(prod_ff);
      unique case (cross_k_ff)
         3'd1:    cross_in = cross_ff + term;
         3'd2:    cross_in = cross_ff + (term <<< HALF_W);
         3'd3:    cross_in = cross_ff - term;
         3'd4:    cross_in = cross_ff - (term <<< HALF_W);
         default: cross_in = cross_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff       <= req_type;
         pix_ff        <= pixel_index;
         sel_ff        <= corner_sel;
         cx_ff         <= coord_x;
         cy_ff         <= coord_y;
         res_status_ff <= 1'b0;
         res_det_x_ff  <= '0;
         res_det_y_ff  <= '0;
         res_found_ff  <= 1'b0;
         res_fpix_ff   <= '0;
      end
      if (cmd.set_bad) begin
         res_status_ff <= 1'b1;
      end
      if (cmd.fwd_cap) begin
         pt_x_ff <= is_corner ? c_rd_x : m_rd_x;
         pt_y_ff <= is_corner ? c_rd_y : m_rd_y;
      end
      if (cmd.ax_start) begin
         ax_div_ff  <= cmd.ax_div;
         ax_neg_ff  <= ax_diff[DIFF_W-1] ^ (cmd.ax_y ? cfg.flip_y : cfg.flip_x);
         ax_mag_ff  <= ax_mag;
         rem_ff     <= '0;
         dq_ff      <= DIV_W'(ax_mag) << FRAC_BITS;
         acc_ff     <= '0;
         mq_ff      <= cfg.mm_per_ch;
         divisor_ff <= (cfg.mm_per_ch == '0) ? 32'd1 : cfg.mm_per_ch;
         ax_cnt_ff  <= cmd.ax_div ? AXC_W'(DIV_W - 1) : AXC_W'(COORD_W - 1);
      end else if (cmd.ax_step) begin
         if (ax_div_ff) begin
            rem_ff <= rem_in;
            dq_ff  <= dq_in;
         end else begin
            acc_ff <= acc_in;
            mq_ff  <= mq_ff << 1;
         end
         ax_cnt_ff <= ax_cnt_ff - AXC_W'(1);
      end
      if (cmd.ax_end) begin
         if (ax_div_ff) begin
            if (cmd.ax_y) res_det_y_ff <= ax_res;
            else          res_det_x_ff <= ax_res;
         end else begin
            if (cmd.ax_y) py_ff <= ax_res;
            else          px_ff <= ax_res;
         end
      end
      if (cmd.scan_clr) begin
         scan_i_ff <= '0;
      end else if (cmd.pix_next) begin
         scan_i_ff <= scan_i_ff + CNT_W'(1);
      end
      if (cmd.pix_rd) begin
         edge_ff <= 2'd0;
      end else if (cmd.edge_next) begin
         edge_ff <= edge_nxt;
      end
      if (cmd.cap_prev) begin
         prev_x_ff <= c_rd_x;
         prev_y_ff <= c_rd_y;
      end else if (cmd.edge_next) begin
         prev_x_ff <= cur_x_ff;
         prev_y_ff <= cur_y_ff;
      end
      if (cmd.cap_cur) begin
         cur_x_ff   <= c_rd_x;
         cur_y_ff   <= c_rd_y;
         da_ff      <= DIFF_W'(c_rd_x) - DIFF_W'(prev_x_ff);
         dc_ff      <= DIFF_W'(c_rd_y) - DIFF_W'(prev_y_ff);
         db_ff      <= DIFF_W'(py_ff) - DIFF_W'(prev_y_ff);
         dd_ff      <= DIFF_W'(px_ff) - DIFF_W'(prev_x_ff);
         cross_k_ff <= 3'd0;
         cross_ff   <= '0;
      end else if (cmd.cross_step) begin
         prod_ff    <= prod_in;
         cross_ff   <= cross_in;
         cross_k_ff <= cross_k_ff + 3'd1;
      end
      if (cmd.set_found) begin
         res_found_ff <= 1'b1;
         res_fpix_ff  <= 5'(scan_i_ff);
      end
      if (cmd.rsp_load) begin
         rsp_status      <= res_status_ff;
         rsp_det_x       <= res_det_x_ff;
         rsp_det_y       <= res_det_y_ff;
         rsp_found       <= res_found_ff;
         rsp_found_pixel <= res_fpix_ff;
      end
   end

   always_comb begin
      sts.kind       = req_kind_type'(kind_ff);
      sts.idx_bad    = pix_w >= eff_w;
      sts.ax_last    = ax_cnt_ff == '0;
      sts.pix_more   = scan_i_ff < CNT_W'(eff_w);
      sts.cross_done = cross_k_ff == 3'd4;
      sts.cross_neg  = cross_ff[CROSS_W-1];
      sts.edge_last  = edge_ff == 2'd3;
   end

endmodule

FILE: hdl/qpcm_ctrl.sv
// ----------------------------------------------------------------------------
// qpcm_ctrl
// Controller: sequences load, forward and reverse requests over the datapath.
// ----------------------------------------------------------------------------
module qpcm_ctrl import qpcm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_FWD_CAP, ST_AX_START, ST_AX_RUN, ST_AX_END,
      ST_PIX, ST_CAP0, ST_EDGE_RD, ST_EDGE_CAP, ST_CROSS, ST_TEST, ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      axis_y_ff, axis_y_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      axis_y_in    = axis_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.ax_y     = axis_y_ff;
      cmd.ax_div   = sts.kind == REQ_FWD;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            axis_y_in = 1'b0;
            unique case (sts.kind)
               REQ_LOAD: begin
                  cmd.load_wr = 1'b1;
                  state_in    = ST_FINISH;
               end
               REQ_FWD: begin
                  if (sts.idx_bad) begin
                     cmd.set_bad = 1'b1;
                     state_in    = ST_FINISH;
                  end else begin
                     cmd.fwd_rd = 1'b1;
                     state_in   = ST_FWD_CAP;
                  end
               end
               REQ_REV: state_in = ST_AX_START;
               default: state_in = ST_FINISH;
            endcase
         end
         ST_FWD_CAP: begin
            cmd.fwd_cap = 1'b1;
            state_in    = ST_AX_START;
         end
         ST_AX_START: begin
            cmd.ax_start = 1'b1;
            state_in     = ST_AX_RUN;
         end
         ST_AX_RUN: begin
            cmd.ax_step = 1'b1;
            if (sts.ax_last) state_in = ST_AX_END;
         end
         ST_AX_END: begin
            cmd.ax_end = 1'b1;
            priority if (!axis_y_ff) begin
               axis_y_in = 1'b1;
               state_in  = ST_AX_START;
            end else if (sts.kind == REQ_FWD) begin
               state_in = ST_FINISH;
            end else begin
               cmd.scan_clr = 1'b1;
               state_in     = ST_PIX;
            end
         end
         ST_PIX: begin
            if (sts.pix_more) begin
               cmd.pix_rd = 1'b1;
               state_in   = ST_CAP0;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_CAP0: begin
            cmd.cap_prev = 1'b1;
            state_in     = ST_EDGE_RD;
         end
         ST_EDGE_RD: begin
            cmd.edge_rd = 1'b1;
            state_in    = ST_EDGE_CAP;
         end
         ST_EDGE_CAP: begin
            cmd.cap_cur = 1'b1;
            state_in    = ST_CROSS;
         end
         ST_CROSS: begin
            cmd.cross_step = 1'b1;
            if (sts.cross_done) state_in = ST_TEST;
         end
         ST_TEST: begin
            priority if (sts.cross_neg) begin
               cmd.pix_next = 1'b1;
               state_in     = ST_PIX;
            end else if (sts.edge_last) begin
               cmd.set_found = 1'b1;
               state_in      = ST_FINISH;
            end else begin
               cmd.edge_next = 1'b1;
               state_in      = ST_EDGE_RD;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_y_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_y_ff    <= axis_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_unit_cmds_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.ax_start, cmd.ax_step, cmd.ax_end, cmd.cross_step, cmd.cap_cur}))
      else $error("axis and edge commands overlap");

   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DECODE))
      else $error("accepted word not decoded");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result word overwritten");

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quad pixel coordinate mapper: random and
// directed request words, a bit-exact predictor and in-order response checks.
// ----------------------------------------------------------------------------
module tb_top;
   import qpcm_pkg::*;

   // request kind that the block leaves unused; it must answer with all zeros
   localparam logic [1:0] REQ_SPARE  = 2'd3;
   localparam logic [2:0] SEL_CENTER = 3'd0;
   localparam int         GRID       = 4 << 16;   // pixel pitch, 4 mm
   localparam int         DRAIN_CYC  = 16;
   localparam logic signed [65:0] SAT_HI = 66'sh7FFFFFFF;
   localparam logic signed [65:0] SAT_LO = -66'sh80000000;

   typedef struct {
      logic [1:0]         kind;
      logic [4:0]         pix;
      logic [2:0]         sel;
      logic signed [31:0] x;
      logic signed [31:0] y;
   } map_word_type;

   typedef struct {
      logic               status;
      logic signed [31:0] det_x;
      logic signed [31:0] det_y;
      logic               found;
      logic [4:0]         found_pixel;
   } map_result_type;

   logic clock;
   logic reset;

   qpcm_req_if req_ch();
   qpcm_rsp_if rsp_ch();
   qpcm_csr_if csr_ch();

   quad_pixel_coordinate_mapper u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ------------------------------------------------------------------------
   // Mapper shadow: register copy and point tables
   // ------------------------------------------------------------------------
   logic [5:0]         pix_count;
   logic signed [31:0] org_x, org_y, ctr_x, ctr_y;
   logic [31:0]        scale;
   logic               flp_x, flp_y;

   logic signed [31:0] corner_x [128];
   logic signed [31:0] corner_y [128];
   logic signed [31:0] mid_x [32];
   logic signed [31:0] mid_y [32];

   map_word_type   word_q[$];     // words waiting for the request driver
   map_result_type result_q[$];   // responses still owed by the block

   int  fail_count = 0;
   bit  req_taken  = 0;
   int  req_gap    = 0;
   int  rsp_stall  = 0;
   int  rsp_hold   = 0;        // long receiver hold-off, in cycles
   bit  calm       = 0;        // no random idling on either side while set

   function automatic logic signed [31:0] sat32(logic signed [65:0] v);
      if (v > SAT_HI) return 32'sh7FFFFFFF;
      if (v < SAT_LO) return 32'sh80000000;
      return v[31:0];
   endfunction

   // pixel plane to detector channels, quotient truncated toward zero
   function automatic logic signed [31:0] to_det(logic signed [31:0] p,
         logic signed [31:0] org, logic signed [31:0] ctr, logic flip);
      logic signed [32:0] d;
      logic [32:0]        m;
      logic [63:0]        q;
      logic signed [65:0] s;
      d = {p[31], p} - {org[31], org};
      m = d[32] ? 33'(-d) : 33'(d);
      q = {31'd0, m} << 16;
      q = q / ((scale == 32'd0) ? 64'd1 : {32'd0, scale});
      s = $signed({2'b00, q});
      if (d[32] != flip) s = -s;
      return sat32(s + $signed({{34{ctr[31]}}, ctr}));
   endfunction

   // detector channels back to the pixel plane
   function automatic logic signed [31:0] to_plane(logic signed [31:0] dv,
         logic signed [31:0] org, logic signed [31:0] ctr, logic flip);
      logic signed [32:0] d;
      logic [32:0]        m;
      logic [63:0]        pr;
      logic signed [65:0] s;
      d  = {dv[31], dv} - {ctr[31], ctr};
      m  = d[32] ? 33'(-d) : 33'(d);
      pr = ({31'd0, m} * {32'd0, scale}) >> 16;
      s  = $signed({2'b00, pr});
      if (d[32] != flip) s = -s;
      return sat32(s + $signed({{34{org[31]}}, org}));
   endfunction

   // every edge cross product of the quad non-negative, computed exactly
   function automatic bit in_quad(int pix, logic signed [31:0] px,
         logic signed [31:0] py);
      int k, n;
      logic signed [32:0] ex, ey, ox, oy;
      logic signed [67:0] lhs, rhs;
      for (int j = 0; j < 4; j++) begin
         k   = pix * 4 + j;
         n   = pix * 4 + ((j + 1) % 4);
         ex  = {corner_x[n][31], corner_x[n]} - {corner_x[k][31], corner_x[k]};
         ey  = {corner_y[n][31], corner_y[n]} - {corner_y[k][31], corner_y[k]};
         ox  = {px[31], px} - {corner_x[k][31], corner_x[k]};
         oy  = {py[31], py} - {corner_y[k][31], corner_y[k]};
         lhs = ex * oy;
         rhs = ey * ox;
         if (lhs < rhs) return 1'b0;
      end
      return 1'b1;
   endfunction

   // work out the response to one word and apply its table write
   function automatic map_result_type map_word(map_word_type w);
      map_result_type r;
      int          lim;
      int          slot;
      logic signed [31:0] px, py;
      r   = '{default: '0};
      lim = (pix_count > 6'd32) ? 32 : int'(pix_count);
      slot = w.pix * 4 + int'(w.sel) - 1;
      case (w.kind)
         REQ_LOAD: begin
            if (w.sel >= CORNER_FIRST && w.sel <= CORNER_LAST) begin
               corner_x[slot] = w.x;
               corner_y[slot] = w.y;
            end else begin
               mid_x[w.pix] = w.x;
               mid_y[w.pix] = w.y;
            end
         end
         REQ_FWD: begin
            if (int'(w.pix) >= lim) begin
               r.status = 1'b1;
            end else begin
               if (w.sel >= CORNER_FIRST && w.sel <= CORNER_LAST) begin
                  px = corner_x[slot];
                  py = corner_y[slot];
               end else begin
                  px = mid_x[w.pix];
                  py = mid_y[w.pix];
               end
               r.det_x = to_det(px, org_x, ctr_x, flp_x);
               r.det_y = to_det(py, org_y, ctr_y, flp_y);
            end
         end
         REQ_REV: begin
            px = to_plane(w.x, org_x, ctr_x, flp_x);
            py = to_plane(w.y, org_y, ctr_y, flp_y);
            for (int i = 0; i < lim; i++) begin
               if (!r.found && in_quad(i, px, py)) begin
                  r.found       = 1'b1;
                  r.found_pixel = 5'(i);
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Idle pattern: mostly short gaps, a few long ones
   // ------------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm)   return 0;
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 15);
      return $urandom_range(30, 80);
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: change at the falling edge, hold until taken
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      map_word_type w;
      logic      nv;
      if (!reset && !(req_ch.valid && !req_taken)) begin
         if (req_taken) begin
            req_taken = 0;
            req_gap   = pick_gap();
            if ($urandom_range(0, 49) == 0) calm = !calm;
         end
         nv = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
         end else if (word_q.size() != 0) begin
            w = word_q.pop_front();
            req_ch.req_type    <= w.kind;
            req_ch.pixel_index <= w.pix;
            req_ch.corner_sel  <= w.sel;
            req_ch.coord_x     <= w.x;
            req_ch.coord_y     <= w.y;
            nv = 1'b1;
         end
         req_ch.valid <= nv;
      end
   end

   // predict at the accepting edge
   always @(posedge clock) begin
      map_word_type w;
      if (!reset && req_ch.valid && req_ch.ready) begin
         w.kind = req_ch.req_type;
         w.pix  = req_ch.pixel_index;
         w.sel  = req_ch.corner_sel;
         w.x    = req_ch.coord_x;
         w.y    = req_ch.coord_y;
         result_q.push_back(map_word(w));
         req_taken = 1;
      end
   end

   // ------------------------------------------------------------------------
   // Response side: random back-pressure plus the long hold-off
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         if ($urandom_range(0, 9) == 0) rsp_stall = pick_gap();
      end
   end

   task automatic report_miss(string fld, logic [31:0] exp_v, logic [31:0] act_v);
      $display("%0t: %s mismatch, expected %h, got %h", $time, fld, exp_v, act_v);
      fail_count++;
   endtask

   always @(posedge clock) begin
      map_result_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (result_q.size() == 0) begin
            $display("%0t: unexpected response word, expected none, got %b/%h/%h/%b/%0d",
                     $time, rsp_ch.status, rsp_ch.det_x, rsp_ch.det_y,
                     rsp_ch.found, rsp_ch.found_pixel);
            fail_count++;
         end else begin
            e = result_q.pop_front();
            if (rsp_ch.status !== e.status)
               report_miss("status", e.status, rsp_ch.status);
            if (rsp_ch.det_x !== e.det_x)
               report_miss("det_x", e.det_x, rsp_ch.det_x);
            if (rsp_ch.det_y !== e.det_y)
               report_miss("det_y", e.det_y, rsp_ch.det_y);
            if (rsp_ch.found !== e.found)
               report_miss("found", e.found, rsp_ch.found);
            if (rsp_ch.found_pixel !== e.found_pixel)
               report_miss("found_pixel", e.found_pixel, rsp_ch.found_pixel);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic send(logic [1:0] kind, logic [4:0] pix, logic [2:0] sel,
                       logic signed [31:0] x, logic signed [31:0] y);
      map_word_type w;
      w = '{kind, pix, sel, x, y};
      word_q.push_back(w);
   endtask

   // block the sender until the block has answered everything
   task automatic drain();
      while (word_q.size() != 0 || req_ch.valid || result_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [31:0] val);
      @(negedge clock);
      csr_ch.valid     <= 1'b1;
      csr_ch.reg_index <= idx;
      csr_ch.wr_data   <= val;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_PIXEL_COUNT: pix_count = val[5:0];
         CSR_ORIGIN_X:    org_x     = val;
         CSR_ORIGIN_Y:    org_y     = val;
         CSR_CENTER_X:    ctr_x     = val;
         CSR_CENTER_Y:    ctr_y     = val;
         CSR_MM_PER_CH:   scale     = val;
         CSR_FLIP_X:      flp_x     = val[0];
         CSR_FLIP_Y:      flp_y     = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic set_mapping(logic [5:0] cnt, logic [31:0] ox, logic [31:0] oy,
         logic [31:0] cx, logic [31:0] cy, logic [31:0] mm, logic fx, logic fy);
      csr_write(CSR_PIXEL_COUNT, {26'd0, cnt});
      csr_write(CSR_ORIGIN_X, ox);
      csr_write(CSR_ORIGIN_Y, oy);
      csr_write(CSR_CENTER_X, cx);
      csr_write(CSR_CENTER_Y, cy);
      csr_write(CSR_MM_PER_CH, mm);
      csr_write(CSR_FLIP_X, {31'd0, fx});
      csr_write(CSR_FLIP_Y, {31'd0, fy});
   endtask

   // nominal layout: an 8 x 4 grid of square pixels, corners counterclockwise
   function automatic logic signed [31:0] grid_x(int pix, int sel);
      int x0;
      x0 = (pix % 8) * GRID - 16 * GRID;
      if (sel == 2 || sel == 3) return x0 + GRID;
      if (sel == 1 || sel == 4) return x0;
      return x0 + GRID / 2;
   endfunction

   function automatic logic signed [31:0] grid_y(int pix, int sel);
      int y0;
      y0 = (pix / 8) * GRID - 8 * GRID;
      if (sel == 3 || sel == 4) return y0 + GRID;
      if (sel == 1 || sel == 2) return y0;
      return y0 + GRID / 2;
   endfunction

   task automatic random_words(int n);
      int r, pix, sel, lim;
      logic signed [31:0] x, y;
      for (int i = 0; i < n; i++) begin
         r   = $urandom_range(0, 99);
         pix = $urandom_range(0, 31);
         sel = $urandom_range(0, 7);
         lim = (pix_count > 6'd32) ? 32 : int'(pix_count);
         if (r < 25) begin
            // mostly nudge a point, now and then scribble over it
            if ($urandom_range(0, 4) != 0) begin
               x = grid_x(pix, sel) + $signed($urandom_range(0, 4096)) - 2048;
               y = grid_y(pix, sel) + $signed($urandom_range(0, 4096)) - 2048;
            end else begin
               x = $urandom();
               y = $urandom();
            end
            send(REQ_LOAD, 5'(pix), 3'(sel), x, y);
         end else if (r < 55) begin
            send(REQ_FWD, 5'(pix), 3'(sel), $urandom(), $urandom());
         end else if (r < 95) begin
            if ($urandom_range(0, 9) < 7) begin
               // aim at a pixel in use, through the current mapping
               if (lim > 0) pix = $urandom_range(0, lim - 1);
               x = to_det(grid_x(pix, 0) + $signed($urandom_range(0, 65536)) - 32768,
                          org_x, ctr_x, flp_x);
               y = to_det(grid_y(pix, 0) + $signed($urandom_range(0, 65536)) - 32768,
                          org_y, ctr_y, flp_y);
            end else begin
               x = $urandom();
               y = $urandom();
            end
            send(REQ_REV, 5'($urandom()), 3'($urandom()), x, y);
         end else begin
            send(REQ_SPARE, 5'(pix), 3'(sel), $urandom(), $urandom());
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.req_type    = REQ_LOAD;
      req_ch.pixel_index = '0;
      req_ch.corner_sel  = SEL_CENTER;
      req_ch.coord_x     = '0;
      req_ch.coord_y     = '0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.reg_index   = CSR_PIXEL_COUNT;
      csr_ch.wr_data     = '0;
      pix_count = 6'd32;
      org_x = 0; org_y = 0; ctr_x = 0; ctr_y = 0;
      scale = 32'h0001_0000;
      flp_x = 0; flp_y = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      set_mapping(6'd32, 0, 0, 0, 0, 32'h0001_0000, 1'b0, 1'b0);

      // fill every table entry so no later read touches an unwritten one
      for (int p = 0; p < 32; p++)
         for (int s = 0; s <= 4; s++)
            send(REQ_LOAD, 5'(p), 3'(s), grid_x(p, s), grid_y(p, s));

      // directed: every corner selector including the aliases of the center
      for (int s = 0; s < 8; s++)
         send(REQ_FWD, 5'd0, 3'(s), 0, 0);
      send(REQ_FWD, 5'd31, CORNER_LAST, 0, 0);
      send(REQ_SPARE, 5'd31, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(REQ_REV, 5'd0, 3'd0, grid_x(0, 0), grid_y(0, 0));
      send(REQ_REV, 5'd0, 3'd0, grid_x(31, 0), grid_y(31, 0));
      // corner shared by four pixels: the lowest index wins
      send(REQ_REV, 5'd0, 3'd0, grid_x(9, 1), grid_y(9, 1));
      send(REQ_REV, 5'd0, 3'd0, 32'sh7FFFFFFF, 32'sh80000000);
      // extreme points: forward result stays at the extremes of the signed range
      send(REQ_LOAD, 5'd30, 3'd2, 32'sh7FFFFFFF, 32'sh80000000);
      send(REQ_FWD, 5'd30, 3'd2, 0, 0);
      send(REQ_LOAD, 5'd30, 3'd2, grid_x(30, 2), grid_y(30, 2));
      send(REQ_LOAD, 5'd30, 3'd6, 32'sh80000000, 32'sh7FFFFFFF);
      send(REQ_FWD, 5'd30, SEL_CENTER, 0, 0);
      send(REQ_LOAD, 5'd30, SEL_CENTER, grid_x(30, 0), grid_y(30, 0));
      random_words(170);
      drain();

      // few pixels, offset and scaled, mirrored in x; receiver holds off long
      set_mapping(6'd8, 32'h0010_0000, 32'hFFFD_0000, 32'h0064_0000,
                  32'hFFCE_0000, 32'h0002_0000, 1'b1, 1'b0);
      rsp_hold = 400;
      random_words(180);
      drain();

      // count above the table size, zero scale, extreme origin and center
      set_mapping(6'd63, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'd0, 1'b1, 1'b1);
      random_words(180);
      drain();

      // empty table range, largest scale
      set_mapping(6'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1);
      random_words(180);
      drain();

      // single pixel, smallest nonzero scale, random offsets
      set_mapping(6'd1, $urandom(), $urandom(), $urandom(), $urandom(),
                  32'd1, 1'b1, 1'b0);
      random_words(180);
      drain();

      // back to a plain layout at half a millimetre per channel
      set_mapping(6'd20, 32'h0000_8000, 32'hFFFF_0000, 32'h0003_0000,
                  32'h0000_0000, 32'h0000_8000, 1'b0, 1'b1);
      random_words(180);
      drain();

      if (fail_count == 0)
         $display("quad_pixel_coordinate_mapper verification clean");
      else
         $display("quad_pixel_coordinate_mapper verification failed");
      $finish;
   end

   // watchdog
   initial begin
      #100_000_000;
      $display("quad_pixel_coordinate_mapper verification failed");
      $finish;
   end

endmodule
